### sv/sitoa_pkg.sv
// Shared types, constants and the digit table for the integer-to-ASCII converter.
package sitoa_pkg;

    // Input word: value to print and radix select
    typedef struct packed {
        logic signed [31:0] value;
        logic               hex_mode;
    } in_word_t;

    // Output word: one character and its end-of-number mark
    typedef struct packed {
        logic [7:0] char_code;
        logic       last;
    } out_word_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // capture a new number
        logic mul;    // reciprocal multiply of the magnitude
        logic div;    // finish one digit, shift the quotient in
        logic emit;   // load the next character into the output register
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic q_zero;     // quotient of the current step is zero
        logic out_free;   // output register can take a character this cycle
        logic emit_last;  // next character to emit is the final one
    } dp_status_t;

    localparam int MAX_DIGITS = 10;
    localparam int CNT_W      = 4;

    // ceil(2^35 / 10): q = (x * RECIP10) >> 35 is exact for any 32-bit x
    localparam logic [31:0] RECIP10    = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    // Digit value to lower-case ASCII
    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] c;
        case (d)
            4'h0: c = 8'h30;
            4'h1: c = 8'h31;
            4'h2: c = 8'h32;
            4'h3: c = 8'h33;
            4'h4: c = 8'h34;
            4'h5: c = 8'h35;
            4'h6: c = 8'h36;
            4'h7: c = 8'h37;
            4'h8: c = 8'h38;
            4'h9: c = 8'h39;
            4'hA: c = 8'h61;
            4'hB: c = 8'h62;
            4'hC: c = 8'h63;
            4'hD: c = 8'h64;
            4'hE: c = 8'h65;
            default: c = 8'h66;
        endcase
        return c;
    endfunction

endpackage

### sv/sitoa_ctrl.sv
// Sequencing state machine for the integer-to-ASCII converter.
module sitoa_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  sitoa_pkg::dp_status_t status,
    output sitoa_pkg::dp_cmd_t    cmd
);
    import sitoa_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Next state and command decode
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div    = 1'b1;
                state_next = status.q_zero ? ST_EMIT : ST_MUL;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    if (status.emit_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // A character is only ever pushed into a free output register
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> status.out_free)
        else $error("emit into occupied output register");

    // A captured number always goes straight to its first multiply
    a_load_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> cmd.mul)
        else $error("load not followed by multiply");

endmodule

### sv/sitoa_dp.sv
// Datapath: magnitude, reciprocal divider, digit buffer and output register.
module sitoa_dp (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sitoa_pkg::in_word_t   s_data,
    input  sitoa_pkg::dp_cmd_t    cmd,
    output sitoa_pkg::dp_status_t status,
    output logic                  m_valid,
    input  logic                  m_ready,
    output sitoa_pkg::out_word_t  m_data
);
    import sitoa_pkg::*;

    logic [31:0]      mag_reg;
    logic             hex_reg;
    logic             sign_pend_reg;
    logic [63:0]      prod_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [7:0]       digit_reg [MAX_DIGITS];
    logic             m_valid_reg;
    out_word_t        m_data_reg;

    logic [31:0]      q_next;
    logic [31:0]      q_dec;
    logic [31:0]      q_times10;
    logic [3:0]       rem;
    logic [CNT_W-1:0] rd_idx;
    out_word_t        char_next;

    // Quotient and remainder of one digit step
    always_comb begin
        q_dec     = {3'b000, prod_reg[63:RECIP_SHIFT]};
        q_times10 = (q_dec << 3) + (q_dec << 1);
        if (hex_reg) begin
            q_next = {4'h0, mag_reg[31:4]};
            rem    = mag_reg[3:0];
        end else begin
            q_next = q_dec;
            rem    = 4'(mag_reg - q_times10);
        end
    end

    // Next character: sign first, then digits from the top of the buffer
    assign rd_idx = cnt_reg - CNT_W'(1);
    always_comb begin
        if (sign_pend_reg) begin
            char_next.char_code = CHAR_MINUS;
            char_next.last      = 1'b0;
        end else begin
            char_next.char_code = digit_reg[rd_idx];
            char_next.last      = (cnt_reg == CNT_W'(1));
        end
    end

    assign status.q_zero    = (q_next == 32'd0);
    assign status.out_free  = !m_valid_reg || m_ready;
    assign status.emit_last = !sign_pend_reg && (cnt_reg == CNT_W'(1));

    // Magnitude and reciprocal product
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mag_reg <= s_data.value[31] ? 32'(~s_data.value + 32'sd1) : 32'(s_data.value);
            hex_reg <= s_data.hex_mode;
        end else if (cmd.div) begin
            mag_reg <= q_next;
        end
        if (cmd.mul) begin
            prod_reg <= 64'(mag_reg) * 64'(RECIP10);
        end
    end

    // Digit buffer, filled least significant first
    always_ff @(posedge aclk) begin
        if (cmd.div) begin
            digit_reg[cnt_reg] <= digit_char(rem);
        end
    end

    // Digit count and pending sign
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg       <= '0;
            sign_pend_reg <= 1'b0;
        end else if (cmd.load) begin
            cnt_reg       <= '0;
            sign_pend_reg <= s_data.value[31];
        end else if (cmd.div) begin
            cnt_reg <= cnt_reg + CNT_W'(1);
        end else if (cmd.emit) begin
            if (sign_pend_reg) begin
                sign_pend_reg <= 1'b0;
            end else begin
                cnt_reg <= rd_idx;
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_data_reg <= char_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // The buffer never holds more digits than a 32-bit magnitude has
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_DIGITS))
        else $error("digit count out of range");

    // A digit is only read back from a non-empty buffer
    a_emit_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && !sign_pend_reg) |-> (cnt_reg != '0))
        else $error("emit from empty digit buffer");

endmodule

### sv/signed_integer_to_ascii_digits_core.sv
// Top level of the signed integer to ASCII text converter.
//
//  channel | ports                     | word                 | direction
//  --------+---------------------------+----------------------+----------
//  input   | s_valid s_ready s_data    | value, hex_mode      | in
//  result  | m_valid m_ready m_data    | char_code, last      | out
//
// One number at a time. After acceptance each digit takes a reciprocal multiply
// step and then a quotient/remainder step in the divider; the characters
// (sign plus digits) then go one per cycle through the output register,
// each one only while that register is free.
// Reset (aresetn, synchronous) returns the sequencer to idle and drops m_valid.
// Output stalls hold the character in the register; s_ready rises as soon as
// the last character is loaded, even while it still waits to be taken.
module signed_integer_to_ascii_digits_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  sitoa_pkg::in_word_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output sitoa_pkg::out_word_t m_data
);
    import sitoa_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    sitoa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    sitoa_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .status  (status),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

### test/ascii_digits_checker.sv
// Watches both channels of the integer-to-ASCII converter and checks every output character.
module ascii_digits_checker (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  sitoa_pkg::in_word_t  s_data,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  sitoa_pkg::out_word_t m_data,
    output int unsigned          mismatches,
    output int unsigned          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import sitoa_pkg::*;

    localparam logic [7:0] CODE_ZERO = 8'h30;  // '0'
    localparam logic [7:0] CODE_A    = 8'h61;  // 'a'
    localparam logic [31:0] BASE_DEC = 32'd10;
    localparam logic [31:0] BASE_HEX = 32'd16;

    // characters still owed by the block, oldest first
    out_word_t expected_text [$];

    // Append the text of one number: optional sign, then digits, top digit first
    task automatic queue_number_text(input in_word_t w);
        logic [31:0] mag;
        logic [31:0] base;
        logic [3:0]  d;
        logic [7:0]  text [$];
        out_word_t   c;
        base = w.hex_mode ? BASE_HEX : BASE_DEC;
        // two's-complement magnitude, so the most negative value stays exact
        mag = w.value[31] ? (~w.value + 32'd1) : w.value;
        do begin
            d = 4'(mag % base);
            text.push_front(d < 4'd10 ? CODE_ZERO + 8'(d) : CODE_A + 8'(d - 4'd10));
            mag = mag / base;
        end while (mag != 32'd0);
        if (w.value[31])
            text.push_front(CHAR_MINUS);
        foreach (text[i]) begin
            c.char_code = text[i];
            c.last      = (i == text.size() - 1);
            expected_text.push_back(c);
        end
    endtask

    // Predict on each accepted number, compare on each accepted character
    always @(posedge aclk) begin
        out_word_t want;
        if (!aresetn) begin
            mismatches = 0;
            expected_text.delete();
        end else begin
            if (s_valid && s_ready)
                queue_number_text(s_data);
            if (m_valid && m_ready) begin
                if (expected_text.size() == 0) begin
                    $display("%0t: unexpected word: expected none, actual char_code %h last %b",
                             $time, m_data.char_code, m_data.last);
                    mismatches = mismatches + 1;
                end else begin
                    want = expected_text.pop_front();
                    if (m_data.char_code !== want.char_code) begin
                        $display("%0t: char_code mismatch: expected %h actual %h",
                                 $time, want.char_code, m_data.char_code);
                        mismatches = mismatches + 1;
                    end
                    if (m_data.last !== want.last) begin
                        $display("%0t: last mismatch: expected %b actual %b",
                                 $time, want.last, m_data.last);
                        mismatches = mismatches + 1;
                    end
                end
            end
        end
        pending <= expected_text.size();
    end

endmodule

### test/signed_integer_to_ascii_digits_core_tb.sv
// Stimulus, reset, clock and verdict for the integer-to-ASCII converter.
module signed_integer_to_ascii_digits_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sitoa_pkg::*;

    localparam int RANDOM_NUMBERS = 220;
    localparam int QUIET_TAIL     = 30;    // final numbers sent with no idling
    localparam int LONG_HOLD      = 300;   // receiver hold-off, in cycles
    localparam int DRAIN_CYCLES   = 40;    // extra wait after the checker's queue is empty

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_word_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_word_t m_data;

    int unsigned mismatches;
    int unsigned pending;

    // set by the sender, read by the receiver
    bit quiet;
    bit long_hold_pending;

    signed_integer_to_ascii_digits_core uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    ascii_digits_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    // Offer one number; valid stays high after acceptance unless a gap follows
    task automatic offer_number(input logic [31:0] value, input logic hex_mode);
        in_word_t w;
        w.value    = value;
        w.hex_mode = hex_mode;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Random value biased toward digit-count boundaries and the extremes
    function automatic logic [31:0] pick_value(input logic hex_mode);
        logic [31:0] p;
        int          k;
        p = 32'd1;
        case ($urandom_range(0, 5))
            0, 1: return $urandom;
            2:    return $urandom_range(0, 20);
            3:    return -$urandom_range(1, 20);
            4: begin
                k = hex_mode ? $urandom_range(1, 7) : $urandom_range(1, 9);
                repeat (k) p = p * (hex_mode ? 32'd16 : 32'd10);
                p = p + $urandom_range(0, 2) - 1;
                return $urandom_range(0, 1) ? -p : p;
            end
            default: begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'hFFFF_FFFF;
                    default: return 32'h8000_0001;
                endcase
            end
        endcase
    endfunction

    // Receiver: random ready bursts, one long hold-off, always ready at the end
    initial begin
        bit long_hold_done;
        long_hold_done = 1'b0;
        m_ready <= 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (long_hold_pending && !long_hold_done) begin
                long_hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else if (!quiet && $urandom_range(0, 2) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end
        end
    end

    // Sender: reset, directed numbers, random numbers, drain, verdict
    initial begin
        logic h;
        quiet             = 1'b0;
        long_hold_pending = 1'b0;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // zero, unit values, full-scale and most negative in both radices
        offer_number(32'd0, 1'b0);
        offer_number(32'd0, 1'b1);
        offer_number(32'd1, 1'b0);
        offer_number(32'hFFFF_FFFF, 1'b0);
        offer_number(32'hFFFF_FFFF, 1'b1);
        offer_number(32'h7FFF_FFFF, 1'b0);
        offer_number(32'h7FFF_FFFF, 1'b1);
        offer_number(32'h8000_0000, 1'b0);
        offer_number(32'h8000_0000, 1'b1);
        offer_number(32'h8000_0001, 1'b0);
        // digit-count boundaries
        offer_number(32'd9, 1'b0);
        offer_number(32'd10, 1'b0);
        offer_number(-32'd10, 1'b0);
        offer_number(32'd15, 1'b1);
        offer_number(32'd16, 1'b1);
        offer_number(32'd999_999_999, 1'b0);
        offer_number(32'd1_000_000_000, 1'b0);
        offer_number(-32'd1_000_000_000, 1'b0);
        offer_number(32'h1000_0000, 1'b1);
        // every hex letter, positive and negative
        offer_number(32'h0ABC_DEF9, 1'b1);
        offer_number(-32'h0FED_CBA1, 1'b1);
        offer_number(32'h0000_00FF, 1'b1);

        for (int n = 0; n < RANDOM_NUMBERS; n++) begin
            if (n == 40)
                long_hold_pending = 1'b1;
            if (n == RANDOM_NUMBERS - QUIET_TAIL)
                quiet = 1'b1;
            h = 1'($urandom_range(0, 1));
            offer_number(pick_value(h), h);
        end
        s_valid <= 1'b0;

        do @(posedge aclk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
